// File: src/wrc_pkg.sv
package wrc_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SIZE_W          = 16;
    localparam int ASPECT_W        = 32;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ASPECT = 3'd0,
        REG_MAX_ASPECT = 3'd1,
        REG_MIN_W      = 3'd2,
        REG_MIN_H      = 3'd3,
        REG_MAX_W      = 3'd4,
        REG_MAX_H      = 3'd5,
        REG_W_STEP     = 3'd6,
        REG_H_STEP     = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] MODE_VMAX = 2'd1;
    localparam logic [1:0] MODE_HMAX = 2'd2;
    localparam logic [1:0] MODE_MAX  = 2'd3;

    typedef struct packed {
        logic drag_left;
        logic drag_top;
        logic pin_x;
        logic pin_y;
    } flags_t;

    typedef struct packed {
        logic [SIZE_W-1:0] rw;
        logic [SIZE_W-1:0] rh;
        logic [SIZE_W-1:0] cw;
        logic [SIZE_W-1:0] ch;
        flags_t            flags;
    } req_t;

    typedef struct packed {
        logic [ASPECT_W-1:0] aspect_lo;
        logic [ASPECT_W-1:0] aspect_hi;
        logic [SIZE_W-1:0]   min_w;
        logic [SIZE_W-1:0]   min_h;
        logic [SIZE_W-1:0]   max_w;
        logic [SIZE_W-1:0]   max_h;
        logic [SIZE_W-1:0]   w_step;
        logic [SIZE_W-1:0]   h_step;
    } cfg_t;

endpackage

// File: src/wrc_front.sv
module wrc_front #(
    parameter int COORD_BITS = wrc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] req_x,
    input  logic signed [COORD_BITS-1:0] req_y,
    input  logic [15:0]                  req_w,
    input  logic [15:0]                  req_h,
    input  logic                         drag_left,
    input  logic                         drag_top,
    input  logic [1:0]                   win_mode,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic [15:0]                  cur_w,
    input  logic [15:0]                  cur_h,
    input  logic                         q_full,
    output logic                         q_push,
    output logic signed [COORD_BITS-1:0] f_x,
    output logic signed [COORD_BITS-1:0] f_y,
    output logic signed [COORD_BITS-1:0] f_cx,
    output logic signed [COORD_BITS-1:0] f_cy,
    output wrc_pkg::req_t                f_req
);

    logic                         vld_reg;
    logic                         accept;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, cx_reg, cy_reg;
    wrc_pkg::req_t                req_reg;
    wrc_pkg::flags_t              flags_next;

    assign busy   = vld_reg & q_full;
    assign accept = start & ~busy;
    assign q_push = vld_reg & ~q_full;

    // classify the maximize mode into per-axis pins
    always_comb
    begin
        flags_next.drag_left = drag_left;
        flags_next.drag_top  = drag_top;
        flags_next.pin_x     = 1'b0;
        flags_next.pin_y     = 1'b0;
        case (win_mode)
            wrc_pkg::MODE_VMAX: flags_next.pin_y = 1'b1;
            wrc_pkg::MODE_HMAX: flags_next.pin_x = 1'b1;
            wrc_pkg::MODE_MAX:
            begin
                flags_next.pin_x = 1'b1;
                flags_next.pin_y = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            vld_reg <= 1'b1;
        end
        else if (q_push)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg         <= req_x;
            y_reg         <= req_y;
            cx_reg        <= cur_x;
            cy_reg        <= cur_y;
            req_reg.rw    <= req_w;
            req_reg.rh    <= req_h;
            req_reg.cw    <= cur_w;
            req_reg.ch    <= cur_h;
            req_reg.flags <= flags_next;
        end
    end

    assign f_x   = x_reg;
    assign f_y   = y_reg;
    assign f_cx  = cx_reg;
    assign f_cy  = cy_reg;
    assign f_req = req_reg;

endmodule

// File: src/wrc_fifo.sv
module wrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/wrc_div.sv
module wrc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] num_a,
    input  logic [DEN_W-1:0] den_a,
    input  logic [NUM_W-1:0] num_b,
    input  logic [DEN_W-1:0] den_b,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_vld,
    output logic [NUM_W-1:0] q_a,
    output logic [DEN_W-1:0] r_a,
    output logic [NUM_W-1:0] q_b,
    output logic [DEN_W-1:0] r_b,
    output logic [TAG_W-1:0] tag_out
);

    typedef struct packed {
        logic [NUM_W-1:0] na;
        logic [NUM_W-1:0] nb;
        logic [NUM_W-1:0] qa;
        logic [NUM_W-1:0] qb;
        logic [DEN_W-1:0] da;
        logic [DEN_W-1:0] db;
        logic [DEN_W-1:0] ra;
        logic [DEN_W-1:0] rb;
        logic [TAG_W-1:0] tag;
    } st_t;

    // one restoring step per stage on both lanes
    function automatic st_t div_step(input st_t p);
        st_t          n;
        logic [DEN_W:0] ta;
        logic [DEN_W:0] tb;
        n    = p;
        ta   = {p.ra, p.na[NUM_W-1]};
        tb   = {p.rb, p.nb[NUM_W-1]};
        n.na = p.na << 1;
        n.nb = p.nb << 1;
        n.qa = p.qa << 1;
        n.qb = p.qb << 1;
        if (ta >= {1'b0, p.da})
        begin
            ta      = ta - {1'b0, p.da};
            n.qa[0] = 1'b1;
        end
        if (tb >= {1'b0, p.db})
        begin
            tb      = tb - {1'b0, p.db};
            n.qb[0] = 1'b1;
        end
        n.ra = ta[DEN_W-1:0];
        n.rb = tb[DEN_W-1:0];
        return n;
    endfunction

    st_t              in_st;
    st_t              st_reg [NUM_W];
    logic [NUM_W-1:0] vld_reg;

    always_comb
    begin
        in_st     = '0;
        in_st.na  = num_a;
        in_st.nb  = num_b;
        in_st.da  = den_a;
        in_st.db  = den_b;
        in_st.tag = tag_in;
    end

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                st_reg[s] <= div_step(in_st);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                st_reg[s] <= div_step(st_reg[s-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[NUM_W-1];
    assign q_a     = st_reg[NUM_W-1].qa;
    assign r_a     = st_reg[NUM_W-1].ra;
    assign q_b     = st_reg[NUM_W-1].qb;
    assign r_b     = st_reg[NUM_W-1].rb;
    assign tag_out = st_reg[NUM_W-1].tag;

endmodule

// File: src/wrc_back.sv
module wrc_back #(
    parameter int COORD_BITS = wrc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrc_pkg::cfg_t                cfg,
    input  logic                         in_vld,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_cx,
    input  logic signed [COORD_BITS-1:0] in_cy,
    input  wrc_pkg::req_t                in_req,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic [15:0]                  out_w,
    output logic [15:0]                  out_h
);

    localparam int C  = COORD_BITS;
    localparam int DW = ((C > 17) ? C : 17) + 2;
    localparam logic signed [DW-1:0] PMAX = (DW'(1) << (C - 1)) - DW'(1);
    localparam logic signed [DW-1:0] PMIN = -PMAX - DW'(1);

    typedef struct packed {
        logic signed [C-1:0] x;
        logic signed [C-1:0] y;
        logic signed [C-1:0] cx;
        logic signed [C-1:0] cy;
        wrc_pkg::req_t       req;
        logic [17:0]         w;
        logic [17:0]         h;
    } work_t;

    typedef struct packed {
        work_t wk;
        logic  en;
    } asp_tag_t;

    typedef struct packed {
        work_t wk;
        logic  neg_w;
        logic  neg_h;
    } snap_tag_t;

    localparam int ASP_TAG_W  = $bits(asp_tag_t);
    localparam int SNAP_TAG_W = $bits(snap_tag_t);

    logic [15:0] mn_aw, mn_ah, mx_aw, mx_ah;
    logic        mn_set, mx_set;

    assign mn_aw  = cfg.aspect_lo[31:16];
    assign mn_ah  = cfg.aspect_lo[15:0];
    assign mx_aw  = cfg.aspect_hi[31:16];
    assign mx_ah  = cfg.aspect_hi[15:0];
    assign mn_set = (|mn_aw) & (|mn_ah);
    assign mx_set = (|mx_aw) & (|mx_ah);

    // min aspect products
    logic        s0_vld_reg;
    work_t       s0_wk_reg;
    logic [31:0] s0_p1_reg, s0_p2_reg;

    always_ff @(posedge clk)
    begin
        s0_wk_reg.x   <= in_x;
        s0_wk_reg.y   <= in_y;
        s0_wk_reg.cx  <= in_cx;
        s0_wk_reg.cy  <= in_cy;
        s0_wk_reg.req <= in_req;
        s0_wk_reg.w   <= 18'(in_req.rw);
        s0_wk_reg.h   <= 18'(in_req.rh);
        s0_p1_reg     <= in_req.rh * mn_aw;
        s0_p2_reg     <= in_req.rw * mn_ah;
    end

    logic [32:0] err_a;
    asp_tag_t    a_tag_in, a_tag_out;
    logic        a_vld;
    logic [31:0] a_qw, a_qh;

    assign err_a        = {1'b0, s0_p1_reg} - {1'b0, s0_p2_reg};
    assign a_tag_in.wk  = s0_wk_reg;
    assign a_tag_in.en  = mn_set & ~err_a[32] & (|err_a[31:0]);

    wrc_div #(
        .NUM_W (32),
        .DEN_W (16),
        .TAG_W (ASP_TAG_W)
    ) u_div_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s0_vld_reg),
        .num_a   (err_a[31:0] - 32'd1),
        .den_a   (mn_ah),
        .num_b   (err_a[31:0] - 32'd1),
        .den_b   (mn_aw),
        .tag_in  (a_tag_in),
        .out_vld (a_vld),
        .q_a     (a_qw),
        .r_a     (),
        .q_b     (a_qh),
        .r_b     (),
        .tag_out (a_tag_out)
    );

    // apply the smaller min aspect correction; height wins a tie
    work_t s1_next, s1_wk_reg;
    logic  s1_vld_reg;

    always_comb
    begin
        s1_next = a_tag_out.wk;
        if (a_tag_out.en)
        begin
            if (a_qw < a_qh)
            begin
                s1_next.w = s1_next.w + 18'(a_qw) + 18'd1;
            end
            else
            begin
                s1_next.h = s1_next.h - 18'(a_qh) - 18'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_wk_reg <= s1_next;
    end

    // max aspect products
    logic        s2_vld_reg;
    work_t       s2_wk_reg;
    logic [32:0] s2_p1_reg;
    logic [31:0] s2_p2_reg;

    always_ff @(posedge clk)
    begin
        s2_wk_reg <= s1_wk_reg;
        s2_p1_reg <= s1_wk_reg.w[16:0] * mx_ah;
        s2_p2_reg <= s1_wk_reg.h[15:0] * mx_aw;
    end

    logic [33:0] err_b;
    asp_tag_t    b_tag_in, b_tag_out;
    logic        b_vld;
    logic [32:0] b_qh, b_qw;

    assign err_b       = {1'b0, s2_p1_reg} - {2'b00, s2_p2_reg};
    assign b_tag_in.wk = s2_wk_reg;
    assign b_tag_in.en = mx_set & ~err_b[33] & (|err_b[32:0]);

    wrc_div #(
        .NUM_W (33),
        .DEN_W (16),
        .TAG_W (ASP_TAG_W)
    ) u_div_max (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s2_vld_reg),
        .num_a   (err_b[32:0] - 33'd1),
        .den_a   (mx_aw),
        .num_b   (err_b[32:0] - 33'd1),
        .den_b   (mx_ah),
        .tag_in  (b_tag_in),
        .out_vld (b_vld),
        .q_a     (b_qh),
        .r_a     (),
        .q_b     (b_qw),
        .r_b     (),
        .tag_out (b_tag_out)
    );

    work_t s3_next, s3_wk_reg;
    logic  s3_vld_reg;

    always_comb
    begin
        s3_next = b_tag_out.wk;
        if (b_tag_out.en)
        begin
            if (b_qw < b_qh)
            begin
                s3_next.w = s3_next.w - 18'(b_qw) - 18'd1;
            end
            else
            begin
                s3_next.h = s3_next.h + 18'(b_qh) + 18'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s3_wk_reg <= s3_next;
    end

    // clamp: min first, max last so max wins
    work_t s4_next, s4_wk_reg;
    logic  s4_vld_reg;

    always_comb
    begin
        s4_next = s3_wk_reg;
        if (18'(cfg.min_w) > s4_next.w)
        begin
            s4_next.w = 18'(cfg.min_w);
        end
        if (18'(cfg.min_h) > s4_next.h)
        begin
            s4_next.h = 18'(cfg.min_h);
        end
        if (18'(cfg.max_w) < s4_next.w)
        begin
            s4_next.w = 18'(cfg.max_w);
        end
        if (18'(cfg.max_h) < s4_next.h)
        begin
            s4_next.h = 18'(cfg.max_h);
        end
    end

    always_ff @(posedge clk)
    begin
        s4_wk_reg <= s4_next;
    end

    // distance above the minimum, as sign and magnitude
    logic [16:0] dw, dh;
    logic [15:0] abs_dw, abs_dh;
    snap_tag_t   c_tag_in, c_tag_out;
    logic        c_vld;
    logic [15:0] c_qw, c_rw, c_qh, c_rh;

    assign dw     = {1'b0, s4_wk_reg.w[15:0]} - {1'b0, cfg.min_w};
    assign dh     = {1'b0, s4_wk_reg.h[15:0]} - {1'b0, cfg.min_h};
    assign abs_dw = dw[16] ? 16'(-dw) : dw[15:0];
    assign abs_dh = dh[16] ? 16'(-dh) : dh[15:0];

    assign c_tag_in.wk    = s4_wk_reg;
    assign c_tag_in.neg_w = dw[16];
    assign c_tag_in.neg_h = dh[16];

    wrc_div #(
        .NUM_W (16),
        .DEN_W (16),
        .TAG_W (SNAP_TAG_W)
    ) u_div_snap (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s4_vld_reg),
        .num_a   (abs_dw),
        .den_a   (cfg.w_step),
        .num_b   (abs_dh),
        .den_b   (cfg.h_step),
        .tag_in  (c_tag_in),
        .out_vld (c_vld),
        .q_a     (c_qw),
        .r_a     (c_rw),
        .q_b     (c_qh),
        .r_b     (c_rh),
        .tag_out (c_tag_out)
    );

    // round-to-nearest step count from quotient and remainder
    function automatic logic [16:0] round_q(input logic [15:0] q, input logic [15:0] r,
                                            input logic [15:0] step, input logic neg);
        logic [16:0] half_dn;
        logic [16:0] half_up;
        logic [16:0] res;
        half_dn = 17'(step >> 1);
        half_up = 17'(step) - half_dn;
        if (!neg)
        begin
            res = 17'(q) + (((17'(r) + half_dn) >= 17'(step)) ? 17'd1 : 17'd0);
        end
        else if (17'(r) >= half_up)
        begin
            res = 17'(q);
        end
        else if (q == 16'd0)
        begin
            res = 17'd0;
        end
        else
        begin
            res = 17'(q) - 17'd1;
        end
        return res;
    endfunction

    logic        s5_vld_reg;
    work_t       s5_wk_reg;
    logic [16:0] s5_qw_reg, s5_qh_reg;
    logic        s5_actw_reg, s5_acth_reg, s5_negw_reg, s5_negh_reg;

    always_ff @(posedge clk)
    begin
        s5_wk_reg   <= c_tag_out.wk;
        s5_qw_reg   <= round_q(c_qw, c_rw, cfg.w_step, c_tag_out.neg_w);
        s5_qh_reg   <= round_q(c_qh, c_rh, cfg.h_step, c_tag_out.neg_h);
        s5_actw_reg <= (|cfg.w_step) & (|c_rw);
        s5_acth_reg <= (|cfg.h_step) & (|c_rh);
        s5_negw_reg <= c_tag_out.neg_w;
        s5_negh_reg <= c_tag_out.neg_h;
    end

    logic        s6_vld_reg;
    work_t       s6_wk_reg;
    logic [32:0] s6_pw_reg, s6_ph_reg;
    logic        s6_actw_reg, s6_acth_reg, s6_negw_reg, s6_negh_reg;

    always_ff @(posedge clk)
    begin
        s6_wk_reg   <= s5_wk_reg;
        s6_pw_reg   <= cfg.w_step * s5_qw_reg;
        s6_ph_reg   <= cfg.h_step * s5_qh_reg;
        s6_actw_reg <= s5_actw_reg;
        s6_acth_reg <= s5_acth_reg;
        s6_negw_reg <= s5_negw_reg;
        s6_negh_reg <= s5_negh_reg;
    end

    function automatic logic [15:0] snap_size(input logic [15:0] cur, input logic [15:0] minv,
                                              input logic [32:0] prod, input logic act,
                                              input logic neg);
        logic [18:0] sz;
        logic [15:0] res;
        sz = neg ? (19'(minv) - 19'(prod[17:0])) : (19'(minv) + 19'(prod[17:0]));
        if (!act)
        begin
            res = cur;
        end
        else if (sz[18])
        begin
            res = 16'd0;
        end
        else if (sz > 19'd65535)
        begin
            res = 16'hFFFF;
        end
        else
        begin
            res = sz[15:0];
        end
        return res;
    endfunction

    logic  s7_vld_reg;
    work_t s7_next, s7_wk_reg;

    always_comb
    begin
        s7_next   = s6_wk_reg;
        s7_next.w = 18'(snap_size(s6_wk_reg.w[15:0], cfg.min_w, s6_pw_reg,
                                  s6_actw_reg, s6_negw_reg));
        s7_next.h = 18'(snap_size(s6_wk_reg.h[15:0], cfg.min_h, s6_ph_reg,
                                  s6_acth_reg, s6_negh_reg));
    end

    always_ff @(posedge clk)
    begin
        s7_wk_reg <= s7_next;
    end

    // drag offset, position saturation, then the maximize pins
    function automatic logic [C-1:0] move_pos(input logic signed [C-1:0] p,
                                             input logic [15:0] sz, input logic [15:0] orig);
        logic signed [DW-1:0] sum;
        logic signed [DW-1:0] szx;
        logic signed [DW-1:0] orx;
        logic [C-1:0]         res;
        szx = DW'(sz);
        orx = DW'(orig);
        sum = DW'(p) + szx - orx;
        if (sum > PMAX)
        begin
            res = PMAX[C-1:0];
        end
        else if (sum < PMIN)
        begin
            res = PMIN[C-1:0];
        end
        else
        begin
            res = sum[C-1:0];
        end
        return res;
    endfunction

    logic                done_reg;
    logic signed [C-1:0] x_next, y_next, x_reg, y_reg;
    logic [15:0]         w_next, h_next, w_reg, h_reg;

    always_comb
    begin
        x_next = s7_wk_reg.x;
        y_next = s7_wk_reg.y;
        w_next = s7_wk_reg.w[15:0];
        h_next = s7_wk_reg.h[15:0];
        if (s7_wk_reg.req.flags.drag_left)
        begin
            x_next = move_pos(s7_wk_reg.x, w_next, s7_wk_reg.req.rw);
        end
        if (s7_wk_reg.req.flags.drag_top)
        begin
            y_next = move_pos(s7_wk_reg.y, h_next, s7_wk_reg.req.rh);
        end
        if (s7_wk_reg.req.flags.pin_y)
        begin
            y_next = s7_wk_reg.cy;
            h_next = s7_wk_reg.req.ch;
        end
        if (s7_wk_reg.req.flags.pin_x)
        begin
            x_next = s7_wk_reg.cx;
            w_next = s7_wk_reg.req.cw;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        w_reg <= w_next;
        h_reg <= h_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= in_vld;
            s1_vld_reg <= a_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= b_vld;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= c_vld;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            done_reg   <= s7_vld_reg;
        end
    end

    assign done  = done_reg;
    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_w = w_reg;
    assign out_h = h_reg;

endmodule

// File: src/window_resize_constrainer_unit.sv
// Window geometry constrainer. Raise start with a request (requested position and size,
// drag flags, maximize mode, current geometry); it is taken at any rising edge where busy
// is low, and one request per cycle is sustained. Each request yields exactly one result,
// shown on out_x/out_y/out_w/out_h for one cycle with done high, in request order. The
// receiver cannot stall: capture the result in the done cycle. The back end holds three
// one-bit-per-stage divider pipelines: 32 stages for the minimum aspect correction, 33
// for the maximum aspect correction and 16 for the increment snap, plus the products,
// clamp and position stages around them. A request first lands in a front register that
// decodes the maximize mode into per-axis pins, then passes through a short queue into
// the arithmetic back end, which never stops. Write the limit registers only while no
// request is in flight.
module window_resize_constrainer_unit #(
    parameter int COORD_BITS  = wrc_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = wrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [wrc_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [wrc_pkg::ASPECT_W-1:0]        cfg_data,
    input  logic signed [COORD_BITS-1:0]        req_x,
    input  logic signed [COORD_BITS-1:0]        req_y,
    input  logic [15:0]                         req_w,
    input  logic [15:0]                         req_h,
    input  logic                                drag_left,
    input  logic                                drag_top,
    input  logic [1:0]                          win_mode,
    input  logic signed [COORD_BITS-1:0]        cur_x,
    input  logic signed [COORD_BITS-1:0]        cur_y,
    input  logic [15:0]                         cur_w,
    input  logic [15:0]                         cur_h,
    output logic                                done,
    output logic signed [COORD_BITS-1:0]        out_x,
    output logic signed [COORD_BITS-1:0]        out_y,
    output logic [15:0]                         out_w,
    output logic [15:0]                         out_h
);

    localparam int QW = 4 * COORD_BITS + $bits(wrc_pkg::req_t);

    // limit registers; aspect halves of zero and steps of zero mean unset
    wrc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.aspect_lo <= '0;
            cfg_reg.aspect_hi <= '0;
            cfg_reg.min_w     <= '0;
            cfg_reg.min_h     <= '0;
            cfg_reg.max_w     <= 16'hFFFF;
            cfg_reg.max_h     <= 16'hFFFF;
            cfg_reg.w_step    <= '0;
            cfg_reg.h_step    <= '0;
        end
        else if (cfg_we)
        begin
            case (wrc_pkg::cfg_idx_t'(cfg_idx))
                wrc_pkg::REG_MIN_ASPECT: cfg_reg.aspect_lo <= cfg_data;
                wrc_pkg::REG_MAX_ASPECT: cfg_reg.aspect_hi <= cfg_data;
                wrc_pkg::REG_MIN_W:      cfg_reg.min_w     <= cfg_data[15:0];
                wrc_pkg::REG_MIN_H:      cfg_reg.min_h     <= cfg_data[15:0];
                wrc_pkg::REG_MAX_W:      cfg_reg.max_w     <= cfg_data[15:0];
                wrc_pkg::REG_MAX_H:      cfg_reg.max_h     <= cfg_data[15:0];
                wrc_pkg::REG_W_STEP:     cfg_reg.w_step    <= cfg_data[15:0];
                wrc_pkg::REG_H_STEP:     cfg_reg.h_step    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front end: hold the request and decode its mode
    logic                         q_push, q_full, q_empty;
    logic signed [COORD_BITS-1:0] f_x, f_y, f_cx, f_cy;
    wrc_pkg::req_t                f_req;

    wrc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_x     (req_x),
        .req_y     (req_y),
        .req_w     (req_w),
        .req_h     (req_h),
        .drag_left (drag_left),
        .drag_top  (drag_top),
        .win_mode  (win_mode),
        .cur_x     (cur_x),
        .cur_y     (cur_y),
        .cur_w     (cur_w),
        .cur_h     (cur_h),
        .q_full    (q_full),
        .q_push    (q_push),
        .f_x       (f_x),
        .f_y       (f_y),
        .f_cx      (f_cx),
        .f_cy      (f_cy),
        .f_req     (f_req)
    );

    // queue between front and back; the back end drains it every cycle
    logic [QW-1:0]                q_wdata, q_rdata;
    logic signed [COORD_BITS-1:0] b_x, b_y, b_cx, b_cy;
    wrc_pkg::req_t                b_req;

    assign q_wdata = {f_x, f_y, f_cx, f_cy, f_req};
    assign {b_x, b_y, b_cx, b_cy, b_req} = q_rdata;

    wrc_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (~q_empty),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    // back end: aspect, clamp, snap, drag and pin
    wrc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_vld (~q_empty),
        .in_x   (b_x),
        .in_y   (b_y),
        .in_cx  (b_cx),
        .in_cy  (b_cy),
        .in_req (b_req),
        .done   (done),
        .out_x  (out_x),
        .out_y  (out_y),
        .out_w  (out_w),
        .out_h  (out_h)
    );

    // the back end never stalls, so the queue must never be pushed while full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("request pushed into a full queue");

    // the queue drains every cycle, so the front end never has to hold off start
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("front end stalled although the back end drains every cycle");

    // a full queue can only follow a cycle in which it was pushed
    assert property (@(posedge clk) disable iff (!rst_n) $rose(q_full) |-> $past(q_push))
        else $error("queue filled without a push");

endmodule

// File: test/wrc_checker.sv
`timescale 1ns / 1ps

module wrc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_data,
    input  logic signed [15:0] req_x,
    input  logic signed [15:0] req_y,
    input  logic [15:0]        req_w,
    input  logic [15:0]        req_h,
    input  logic               drag_left,
    input  logic               drag_top,
    input  logic [1:0]         win_mode,
    input  logic signed [15:0] cur_x,
    input  logic signed [15:0] cur_y,
    input  logic [15:0]        cur_w,
    input  logic [15:0]        cur_h,
    input  logic               done,
    input  logic signed [15:0] out_x,
    input  logic signed [15:0] out_y,
    input  logic [15:0]        out_w,
    input  logic [15:0]        out_h,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } geom_t;

    geom_t geom_q[$];
    logic [31:0] lim_aspect_lo, lim_aspect_hi;
    longint lim_min_w, lim_min_h, lim_max_w, lim_max_h, lim_w_step, lim_h_step;

    assign pending = geom_q.size();

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint cdiv(longint n, longint d);
        return (n + d - 1) / d;
    endfunction

    function automatic longint snap_size(longint s, longint mn, longint st);
        longint d;
        if (st == 0) return s;
        d = s - mn;
        if (d % st != 0) s = mn + st * (((2 * d + st) / 2) / st);
        return s;
    endfunction

    function automatic geom_t constrain_geom();
        longint w, h, x, y, aw, ah, e, wc, hc;
        geom_t g;
        w = req_w; h = req_h; x = req_x; y = req_y;
        aw = lim_aspect_lo[31:16]; ah = lim_aspect_lo[15:0];
        if (aw != 0 && ah != 0)
        begin
            e = h * aw - w * ah;
            if (e > 0)
            begin
                wc = cdiv(e, ah); hc = cdiv(e, aw);
                if (wc < hc) w += wc; else h -= hc;
            end
        end
        aw = lim_aspect_hi[31:16]; ah = lim_aspect_hi[15:0];
        if (aw != 0 && ah != 0)
        begin
            e = w * ah - h * aw;
            if (e > 0)
            begin
                hc = cdiv(e, aw); wc = cdiv(e, ah);
                if (wc < hc) w -= wc; else h += hc;
            end
        end
        if (lim_min_w > w) w = lim_min_w;
        if (lim_min_h > h) h = lim_min_h;
        if (lim_max_w < w) w = lim_max_w;
        if (lim_max_h < h) h = lim_max_h;
        w = clip(snap_size(w, lim_min_w, lim_w_step), 0, 65535);
        h = clip(snap_size(h, lim_min_h, lim_h_step), 0, 65535);
        if (drag_left) x = clip(x + (w - req_w), -32768, 32767);
        if (drag_top)  y = clip(y + (h - req_h), -32768, 32767);
        if (win_mode == wrc_pkg::MODE_VMAX || win_mode == wrc_pkg::MODE_MAX)
        begin
            y = cur_y; h = cur_h;
        end
        if (win_mode == wrc_pkg::MODE_HMAX || win_mode == wrc_pkg::MODE_MAX)
        begin
            x = cur_x; w = cur_w;
        end
        g.x = x[15:0]; g.y = y[15:0]; g.w = w[15:0]; g.h = h[15:0];
        return g;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        geom_t g;
        if (!rst_n)
        begin
            fail_count    = 0;
            lim_aspect_lo = 0;
            lim_aspect_hi = 0;
            lim_min_w = 0; lim_min_h = 0;
            lim_max_w = 65535; lim_max_h = 65535;
            lim_w_step = 0; lim_h_step = 0;
        end
        else
        begin
            if (done)
            begin
                if (geom_q.size() == 0) report_mismatch("unexpected result", 0, 0);
                else
                begin
                    g = geom_q.pop_front();
                    if (out_x !== g.x) report_mismatch("out_x", out_x, $signed(g.x));
                    if (out_y !== g.y) report_mismatch("out_y", out_y, $signed(g.y));
                    if (out_w !== g.w) report_mismatch("out_w", out_w, g.w);
                    if (out_h !== g.h) report_mismatch("out_h", out_h, g.h);
                end
            end
            // predict with the limits in force before this edge's write
            if (start && !busy) geom_q.push_back(constrain_geom());
            if (cfg_we)
            begin
                case (wrc_pkg::cfg_idx_t'(cfg_idx))
                    wrc_pkg::REG_MIN_ASPECT: lim_aspect_lo = cfg_data;
                    wrc_pkg::REG_MAX_ASPECT: lim_aspect_hi = cfg_data;
                    wrc_pkg::REG_MIN_W:      lim_min_w = cfg_data[15:0];
                    wrc_pkg::REG_MIN_H:      lim_min_h = cfg_data[15:0];
                    wrc_pkg::REG_MAX_W:      lim_max_w = cfg_data[15:0];
                    wrc_pkg::REG_MAX_H:      lim_max_h = cfg_data[15:0];
                    wrc_pkg::REG_W_STEP:     lim_w_step = cfg_data[15:0];
                    wrc_pkg::REG_H_STEP:     lim_h_step = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import wrc_pkg::*;

    localparam int LATENCY     = 91;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic signed [15:0] req_x = '0, req_y = '0, cur_x = '0, cur_y = '0;
    logic [15:0] req_w = '0, req_h = '0, cur_w = '0, cur_h = '0;
    logic drag_left = 1'b0, drag_top = 1'b0;
    logic [1:0] win_mode = '0;
    logic done;
    logic signed [15:0] out_x, out_y;
    logic [15:0] out_w, out_h;
    int fail_count, pending;
    int idle_cycles;
    bit timed_out;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    window_resize_constrainer_unit u_dut (.*);

    wrc_checker u_chk (.*);

    // Watchdog: count cycles with no request taken and no result seen.
    always @(posedge clk) begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL window_resize_constrainer_unit");
            $finish;
        end
    end

    // Write one limit register; the block must be idle.
    task automatic write_limit(cfg_idx_t idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Hold until every predicted result has come, then let the pipe drain.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Pick a size: mostly small and mid values, sometimes the extremes.
    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [31:0] pick_aspect();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return {16'd0, 16'($urandom_range(1, 20))};
            2: return 32'($urandom);
            default: return {16'($urandom_range(1, 20)), 16'($urandom_range(1, 20))};
        endcase
    endfunction

    // Drive one request, keeping start high across back-to-back requests.
    task automatic send_request(logic signed [15:0] rx, logic signed [15:0] ry,
                                logic [15:0] rw, logic [15:0] rh, logic dl, logic dt,
                                logic [1:0] md, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_x     <= rx;
        req_y     <= ry;
        req_w     <= rw;
        req_h     <= rh;
        drag_left <= dl;
        drag_top  <= dt;
        win_mode  <= md;
        cur_x     <= 16'($urandom);
        cur_y     <= 16'($urandom);
        cur_w     <= 16'($urandom);
        cur_h     <= 16'($urandom);
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_random(bit gaps);
        send_request(16'($urandom), 16'($urandom), pick_size(), pick_size(),
                     1'($urandom), 1'($urandom), 2'($urandom), gaps);
    endtask

    task automatic load_limits(int phase);
        logic [15:0] mn_w, mn_h;
        mn_w = phase[0] ? 16'($urandom_range(0, 300)) : 16'd0;
        mn_h = phase[1] ? 16'($urandom_range(0, 300)) : 16'd0;
        write_limit(REG_MIN_ASPECT, pick_aspect());
        write_limit(REG_MAX_ASPECT, pick_aspect());
        write_limit(REG_MIN_W, mn_w);
        write_limit(REG_MIN_H, mn_h);
        // now and then push min above max so the max clamp wins
        write_limit(REG_MAX_W, $urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 200))
                                                         : 16'($urandom_range(300, 65535)));
        write_limit(REG_MAX_H, $urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 200))
                                                         : 16'($urandom_range(300, 65535)));
        write_limit(REG_W_STEP, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 40)));
        write_limit(REG_H_STEP, $urandom_range(0, 9) == 0 ? 16'hFFFF
                                                          : 16'($urandom_range(0, 40)));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset limits, position and size extremes, every mode.
        send_request(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 2'd0, 0);
        send_request(-16'sd32768, -16'sd32768, 16'd0, 16'd0, 1'b1, 1'b1, 2'd0, 0);
        send_request(16'sd10, 16'sd20, 16'd100, 16'd50, 1'b0, 1'b0, MODE_VMAX, 0);
        send_request(16'sd10, 16'sd20, 16'd100, 16'd50, 1'b0, 1'b0, MODE_HMAX, 0);
        send_request(16'sd10, 16'sd20, 16'd100, 16'd50, 1'b1, 1'b1, MODE_MAX, 0);
        drain();

        // Aspect both ways and an exact ratio, a min clamp, steps and drags saturating.
        write_limit(REG_MIN_ASPECT, {16'd4, 16'd3});
        write_limit(REG_MAX_ASPECT, {16'd16, 16'd9});
        write_limit(REG_MIN_W, 16'd200);
        write_limit(REG_MIN_H, 16'd150);
        write_limit(REG_MAX_W, 16'd1920);
        write_limit(REG_MAX_H, 16'd1080);
        write_limit(REG_W_STEP, 16'd8);
        write_limit(REG_H_STEP, 16'd16);
        send_request(16'sd0, 16'sd0, 16'd100, 16'd900, 1'b1, 1'b1, 2'd0, 0);
        send_request(16'sd0, 16'sd0, 16'd900, 16'd100, 1'b1, 1'b1, 2'd0, 0);
        send_request(-16'sd32768, 16'sh7FFF, 16'd3000, 16'd3000, 1'b1, 1'b1, 2'd0, 0);
        send_request(16'sh7FFF, -16'sd32768, 16'd0, 16'd0, 1'b1, 1'b1, 2'd0, 0);
        send_request(16'sd5, 16'sd5, 16'd404, 16'd303, 1'b0, 1'b1, 2'd0, 0);
        send_request(16'sd5, 16'sd5, 16'd12, 16'd12, 1'b1, 1'b0, 2'd0, 0);
        drain();

        // Min above max; unset aspect halves; max step forces saturation.
        write_limit(REG_MIN_ASPECT, {16'd0, 16'd3});
        write_limit(REG_MAX_ASPECT, {16'd5, 16'd0});
        write_limit(REG_MIN_W, 16'hFFFF);
        write_limit(REG_MAX_W, 16'd10);
        write_limit(REG_MIN_H, 16'd0);
        write_limit(REG_MAX_H, 16'hFFFF);
        write_limit(REG_W_STEP, 16'hFFFF);
        write_limit(REG_H_STEP, 16'hFFFF);
        send_request(16'sd0, 16'sd0, 16'd50, 16'd40000, 1'b1, 1'b1, 2'd0, 0);
        send_request(16'sd0, 16'sd0, 16'd5, 16'd65534, 1'b1, 1'b1, 2'd0, 0);
        send_request(16'sd0, 16'sd0, 16'd65535, 16'd1, 1'b0, 1'b0, 2'd0, 0);
        drain();

        // Random phases; the last one runs without gaps.
        for (int ph = 0; ph < 14; ph++) begin
            load_limits(ph);
            for (int n = 0; n < 125; n++) send_random(ph < 13);
            drain();
        end

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0) $display("PASS window_resize_constrainer_unit");
        else $display("FAIL window_resize_constrainer_unit");
        $finish;
    end
endmodule

// File: sim.f
src/wrc_pkg.sv
src/wrc_front.sv
src/wrc_fifo.sv
src/wrc_div.sv
src/wrc_back.sv
src/window_resize_constrainer_unit.sv
test/wrc_checker.sv
test/tb.sv
